[rtl/wmfd_pkg.sv]
// shared types, constants and codes of the wlan mac frame dispatcher
package wmfd_pkg;

  // transmit queue geometry
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LIMIT_W     = 5;
  localparam int unsigned CMP_W       = (QCNT_W > LIMIT_W) ? QCNT_W : LIMIT_W;

  // field widths
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned SEQ_W  = 12;
  localparam int unsigned DUR_W  = 15;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned SIFS_W = 8;
  localparam int unsigned AIR_W  = 12;
  localparam int unsigned SUM_W  = 13;

  // apb register map
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam logic [2:0] REG_QUEUE_LIMIT   = 3'd0;
  localparam logic [2:0] REG_RTS_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_FRAG_THRESH   = 3'd2;
  localparam logic [2:0] REG_SIFS          = 3'd3;
  localparam logic [2:0] REG_ACK_AIRTIME   = 3'd4;
  localparam logic [2:0] REG_CTS_AIRTIME   = 3'd5;

  // register reset values
  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST = '0;
  localparam logic [LEN_W-1:0]   RTS_THRESH_RST  = 16'd2346;
  localparam logic [LEN_W-1:0]   FRAG_THRESH_RST = 16'd2346;
  localparam logic [SIFS_W-1:0]  SIFS_RST        = 8'd10;
  localparam logic [AIR_W-1:0]   ACK_AIR_RST     = 12'd304;
  localparam logic [AIR_W-1:0]   CTS_AIR_RST     = 12'd304;

  // received frame types; any other code counts as other
  localparam logic [1:0] RX_RTS  = 2'd0;
  localparam logic [1:0] RX_DATA = 2'd1;

  typedef enum logic [1:0] {
    ACT_TX_FRAME  = 2'd0,
    ACT_RX_FRAME  = 2'd1,
    ACT_XCHG_DONE = 2'd2,
    ACT_TX_DONE   = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    RES_DROP_FULL   = 4'd0,
    RES_REJECT_LONG = 4'd1,
    RES_QUEUED      = 4'd2,
    RES_START       = 4'd3,
    RES_SEND_ACK    = 4'd4,
    RES_SEND_CTS    = 4'd5,
    RES_DELIVER     = 4'd6,
    RES_PASS_XCHG   = 4'd7,
    RES_DROP_RX     = 4'd8,
    RES_IDLE        = 4'd9
  } res_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_SECOND = 2'd2
  } fsm_e;

  typedef struct packed {
    res_kind_e          kind;
    logic [TAG_W-1:0]   tag;
    logic [SEQ_W-1:0]   seq;
    logic               use_rts;
    logic [DUR_W-1:0]   dur;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] seq;
  } entry_t;

endpackage

[rtl/wmfd_if.sv]
// stream interfaces for dispatcher events and results

interface wmfd_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [wmfd_pkg::TAG_W-1:0] frame_tag;
  logic [wmfd_pkg::LEN_W-1:0] byte_length;
  logic [1:0]                 rx_kind;
  logic [wmfd_pkg::DUR_W-1:0] rx_duration;
  logic                       rx_more_fragments;

  modport source (
    output valid, action, frame_tag, byte_length, rx_kind, rx_duration, rx_more_fragments,
    input  ready
  );
  modport sink (
    input  valid, action, frame_tag, byte_length, rx_kind, rx_duration, rx_more_fragments,
    output ready
  );
endinterface

interface wmfd_out_if;
  logic                        valid;
  logic                        ready;
  logic [wmfd_pkg::KIND_W-1:0] result_kind;
  logic [wmfd_pkg::TAG_W-1:0]  out_tag;
  logic [wmfd_pkg::SEQ_W-1:0]  seq_number;
  logic                        use_rts;
  logic [wmfd_pkg::DUR_W-1:0]  reply_duration;
  logic                        last;

  modport source (
    output valid, result_kind, out_tag, seq_number, use_rts, reply_duration, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, out_tag, seq_number, use_rts, reply_duration, last,
    output ready
  );
endinterface

[rtl/wlan_mac_frame_dispatch_top.sv]
// wlan mac frame dispatcher: event decode, transmit queue memory and apb registers
// the first result is registered in the EXEC step after the event transfer, a data frame's
//   second result in the SECOND step after that; output stalls extend this
// a new event is taken only in IDLE, after the previous one has passed its take and execute steps
// reset: pointers, count, busy flag, sequence number and registers cleared to defaults;
//   queue memory contents are undefined and never read before written
module wlan_mac_frame_dispatch_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  wmfd_in_if.sink                          in_i,
  wmfd_out_if.source                       out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wmfd_pkg::PADDR_W-1:0]     paddr,
  input  logic [wmfd_pkg::PDATA_W-1:0]     pwdata,
  output logic [wmfd_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  // configuration registers
  logic [wmfd_pkg::LIMIT_W-1:0] cfg_limit_q;
  logic [wmfd_pkg::LEN_W-1:0]   cfg_rts_q;
  logic [wmfd_pkg::LEN_W-1:0]   cfg_frag_q;
  logic [wmfd_pkg::SIFS_W-1:0]  cfg_sifs_q;
  logic [wmfd_pkg::AIR_W-1:0]   cfg_ack_q;
  logic [wmfd_pkg::AIR_W-1:0]   cfg_cts_q;
  logic                         cfg_we;
  logic [2:0]                   cfg_idx;

  // control state
  wmfd_pkg::fsm_e               state_q, state_d;
  logic [wmfd_pkg::QIDX_W-1:0]  head_q, head_d;
  logic [wmfd_pkg::QIDX_W-1:0]  tail_q, tail_d;
  logic [wmfd_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                         busy_q, busy_d;
  logic [wmfd_pkg::SEQ_W-1:0]   nseq_q, nseq_d;

  // captured event
  wmfd_pkg::action_e            act_q;
  logic [wmfd_pkg::TAG_W-1:0]   tag_q;
  logic [wmfd_pkg::LEN_W-1:0]   len_q;
  logic [1:0]                   rxk_q;
  logic [wmfd_pkg::DUR_W-1:0]   dur_q;
  logic                         mf_q;

  // queue memory
  wmfd_pkg::entry_t             mem_q [wmfd_pkg::QUEUE_DEPTH];
  wmfd_pkg::entry_t             rd_q;
  wmfd_pkg::entry_t             wr_entry;
  logic                         mem_we;

  // result register
  wmfd_pkg::result_t            out_q, res;
  logic                         out_valid_q, out_valid_d;
  logic                         out_free;
  logic                         load;

  // datapath helpers
  logic                         in_take;
  logic                         full;
  logic [wmfd_pkg::CMP_W-1:0]   cnt_cmp, lim_cmp;
  logic [wmfd_pkg::SUM_W-1:0]   ack_sum, cts_sum;
  logic [wmfd_pkg::DUR_W-1:0]   ack_dur, cts_dur;

  function automatic logic [wmfd_pkg::QIDX_W-1:0] next_idx(
    input logic [wmfd_pkg::QIDX_W-1:0] idx
  );
    logic [wmfd_pkg::QIDX_W-1:0] nxt;
    if (idx == wmfd_pkg::QIDX_W'(wmfd_pkg::QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + 1'b1;
    end
    return nxt;
  endfunction

  // apb access decode
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite;

  always_comb begin
    unique case (cfg_idx)
      wmfd_pkg::REG_QUEUE_LIMIT:   prdata = wmfd_pkg::PDATA_W'(cfg_limit_q);
      wmfd_pkg::REG_RTS_THRESHOLD: prdata = wmfd_pkg::PDATA_W'(cfg_rts_q);
      wmfd_pkg::REG_FRAG_THRESH:   prdata = wmfd_pkg::PDATA_W'(cfg_frag_q);
      wmfd_pkg::REG_SIFS:          prdata = wmfd_pkg::PDATA_W'(cfg_sifs_q);
      wmfd_pkg::REG_ACK_AIRTIME:   prdata = wmfd_pkg::PDATA_W'(cfg_ack_q);
      wmfd_pkg::REG_CTS_AIRTIME:   prdata = wmfd_pkg::PDATA_W'(cfg_cts_q);
      default:                     prdata = '0;
    endcase
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_limit_q <= wmfd_pkg::QUEUE_LIMIT_RST;
      cfg_rts_q   <= wmfd_pkg::RTS_THRESH_RST;
      cfg_frag_q  <= wmfd_pkg::FRAG_THRESH_RST;
      cfg_sifs_q  <= wmfd_pkg::SIFS_RST;
      cfg_ack_q   <= wmfd_pkg::ACK_AIR_RST;
      cfg_cts_q   <= wmfd_pkg::CTS_AIR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        wmfd_pkg::REG_QUEUE_LIMIT:   cfg_limit_q <= pwdata[wmfd_pkg::LIMIT_W-1:0];
        wmfd_pkg::REG_RTS_THRESHOLD: cfg_rts_q   <= pwdata[wmfd_pkg::LEN_W-1:0];
        wmfd_pkg::REG_FRAG_THRESH:   cfg_frag_q  <= pwdata[wmfd_pkg::LEN_W-1:0];
        wmfd_pkg::REG_SIFS:          cfg_sifs_q  <= pwdata[wmfd_pkg::SIFS_W-1:0];
        wmfd_pkg::REG_ACK_AIRTIME:   cfg_ack_q   <= pwdata[wmfd_pkg::AIR_W-1:0];
        wmfd_pkg::REG_CTS_AIRTIME:   cfg_cts_q   <= pwdata[wmfd_pkg::AIR_W-1:0];
        default: ;
      endcase
    end
  end

  // event handshake
  assign in_i.ready = (state_q == wmfd_pkg::ST_IDLE);
  assign in_take    = in_i.valid & in_i.ready;
  assign out_free   = ~out_valid_q | out_o.ready;

  // event capture
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q <= wmfd_pkg::action_e'(in_i.action);
      tag_q <= in_i.frame_tag;
      len_q <= in_i.byte_length;
      rxk_q <= in_i.rx_kind;
      dur_q <= in_i.rx_duration;
      mf_q  <= in_i.rx_more_fragments;
    end
  end

  // queue memory: write at tail, head read registered every cycle
  // a pushed entry is written before the next event's execute step can read it
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= wr_entry;
    end
    rd_q <= mem_q[head_q];
  end

  // queue full test against the limit register and the memory depth
  assign cnt_cmp = wmfd_pkg::CMP_W'(count_q);
  assign lim_cmp = wmfd_pkg::CMP_W'(cfg_limit_q);
  assign full    = ((cfg_limit_q != '0) && (cnt_cmp >= lim_cmp)) ||
                   (count_q >= wmfd_pkg::QCNT_W'(wmfd_pkg::QUEUE_DEPTH));

  // reply durations, saturating at zero
  assign ack_sum = wmfd_pkg::SUM_W'(cfg_sifs_q) + wmfd_pkg::SUM_W'(cfg_ack_q);
  assign cts_sum = wmfd_pkg::SUM_W'(cfg_sifs_q) + wmfd_pkg::SUM_W'(cfg_cts_q);
  assign ack_dur = (dur_q > wmfd_pkg::DUR_W'(ack_sum)) ?
                   dur_q - wmfd_pkg::DUR_W'(ack_sum) : '0;
  assign cts_dur = (dur_q > wmfd_pkg::DUR_W'(cts_sum)) ?
                   dur_q - wmfd_pkg::DUR_W'(cts_sum) : '0;

  assign wr_entry = '{tag: tag_q, len: len_q, seq: nseq_q};

  // sequencer: next state, state updates and result
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    busy_d  = busy_q;
    nseq_d  = nseq_q;
    mem_we  = 1'b0;
    load    = 1'b0;
    res      = '0;
    res.kind = wmfd_pkg::RES_IDLE;
    res.tag  = tag_q;
    res.last = 1'b1;
    unique case (state_q)
      wmfd_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = wmfd_pkg::ST_EXEC;
        end
      end
      wmfd_pkg::ST_EXEC: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = wmfd_pkg::ST_IDLE;
          unique case (act_q)
            wmfd_pkg::ACT_TX_FRAME: begin
              if (full) begin
                res.kind = wmfd_pkg::RES_DROP_FULL;
              end else if (len_q > cfg_frag_q) begin
                res.kind = wmfd_pkg::RES_REJECT_LONG;
              end else begin
                res.seq = nseq_q;
                nseq_d  = nseq_q + 1'b1;
                if (busy_q) begin
                  // exchange running: push to the queue
                  res.kind = wmfd_pkg::RES_QUEUED;
                  mem_we   = 1'b1;
                  tail_d   = next_idx(tail_q);
                  count_d  = count_q + 1'b1;
                end else begin
                  res.kind    = wmfd_pkg::RES_START;
                  res.use_rts = (len_q >= cfg_rts_q);
                  busy_d      = 1'b1;
                end
              end
            end
            wmfd_pkg::ACT_RX_FRAME: begin
              if (rxk_q == wmfd_pkg::RX_RTS) begin
                res.kind = wmfd_pkg::RES_SEND_CTS;
                res.dur  = cts_dur;
              end else if (rxk_q == wmfd_pkg::RX_DATA) begin
                // ack first, delivery upward follows
                res.kind = wmfd_pkg::RES_SEND_ACK;
                res.dur  = mf_q ? ack_dur : '0;
                res.last = 1'b0;
                state_d  = wmfd_pkg::ST_SECOND;
              end else begin
                res.kind = busy_q ? wmfd_pkg::RES_PASS_XCHG : wmfd_pkg::RES_DROP_RX;
              end
            end
            wmfd_pkg::ACT_XCHG_DONE: begin
              busy_d = 1'b0;
              if (count_q != '0) begin
                // pop the head and start it
                res.kind    = wmfd_pkg::RES_START;
                res.tag     = rd_q.tag;
                res.seq     = rd_q.seq;
                res.use_rts = (rd_q.len >= cfg_rts_q);
                head_d      = next_idx(head_q);
                count_d     = count_q - 1'b1;
                busy_d      = 1'b1;
              end
            end
            wmfd_pkg::ACT_TX_DONE: begin
              res.kind = busy_q ? wmfd_pkg::RES_PASS_XCHG : wmfd_pkg::RES_IDLE;
            end
          endcase
        end
      end
      wmfd_pkg::ST_SECOND: begin
        if (out_free) begin
          load     = 1'b1;
          res.kind = wmfd_pkg::RES_DELIVER;
          state_d  = wmfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wmfd_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmfd_pkg::ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      busy_q  <= 1'b0;
      nseq_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      busy_q  <= busy_d;
      nseq_q  <= nseq_d;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q & ~out_o.ready;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_kind    = out_q.kind;
  assign out_o.out_tag        = out_q.tag;
  assign out_o.seq_number     = out_q.seq;
  assign out_o.use_rts        = out_q.use_rts;
  assign out_o.reply_duration = out_q.dur;
  assign out_o.last           = out_q.last;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= wmfd_pkg::QCNT_W'(wmfd_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with unequal pointers");

  a_second_is_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wmfd_pkg::ST_SECOND && out_valid_q) |->
      (out_q.kind == wmfd_pkg::RES_SEND_ACK && !out_q.last))
    else $error("second result without pending ack");

  a_queued_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == wmfd_pkg::RES_QUEUED) |-> busy_q)
    else $error("frame queued while no exchange runs");

endmodule
